// File: hw/rtl/power_window_controller_unit_assert.svh
// Assertion macros used by the power window controller top-level RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef POWER_WINDOW_CONTROLLER_UNIT_ASSERT_SVH
`define POWER_WINDOW_CONTROLLER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checks a property that must hold at every clock edge out of reset.
`define PWC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("power window controller: property violated");
// Checks that a condition never becomes true out of reset.
`define PWC_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("power window controller: forbidden condition");
`else
`define PWC_ASSERT(lbl, prop)
`define PWC_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/pwc_pkg.sv
// Shared constants and types of the power window controller.
// No dependencies; used by every RTL file of the block.
package pwc_pkg;

  localparam int TIMER_BITS_DEF = 12;
  localparam int CFG_W          = 12;
  localparam int CFG_IDX_W      = 4;
  localparam int LV_W           = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 4'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 12'd50;
  localparam logic [CFG_W-1:0] HOLD_RST     = 12'd1000;
  localparam logic [CFG_W-1:0] OBSTACLE_RST = 12'd100;
  localparam logic [CFG_W-1:0] REVERSE_RST  = 12'd1000;

  // Bit positions in the sampled level vector.
  localparam int LV_PU   = 0;
  localparam int LV_PD   = 1;
  localparam int LV_DU   = 2;
  localparam int LV_DD   = 3;
  localparam int LV_OBS  = 4;
  localparam int LV_LOCK = 5;
  localparam int LV_TOP  = 6;
  localparam int LV_BOT  = 7;

  localparam logic [1:0] M_STOP = 2'd0;
  localparam logic [1:0] M_UP   = 2'd1;
  localparam logic [1:0] M_DOWN = 2'd2;

  localparam logic [2:0] O_NONE   = 3'd0;
  localparam logic [2:0] O_DRIVER = 3'd1;
  localparam logic [2:0] O_PASS   = 3'd2;
  localparam logic [2:0] O_LIMIT  = 3'd3;
  localparam logic [2:0] O_OBST   = 3'd4;

  localparam logic [2:0] P_IDLE     = 3'd0;
  localparam logic [2:0] P_DEBOUNCE = 3'd1;
  localparam logic [2:0] P_HOLD     = 3'd2;
  localparam logic [2:0] P_MANUAL   = 3'd3;
  localparam logic [2:0] P_ONETOUCH = 3'd4;
  localparam logic [2:0] P_REVERSE  = 3'd5;

  localparam logic [2:0] B_NONE = 3'd0;
  localparam logic [2:0] B_DU   = 3'd1;
  localparam logic [2:0] B_DD   = 3'd2;
  localparam logic [2:0] B_PU   = 3'd3;
  localparam logic [2:0] B_PD   = 3'd4;

  // Controller state other than the timers.
  typedef struct packed {
    logic [1:0]      motor;
    logic [2:0]      owner;
    logic [2:0]      phase;
    logic [2:0]      button;
    logic [LV_W-1:0] prev;
  } pwc_ctrl_t;

endpackage

// File: hw/rtl/power_window_controller_unit.sv
// Power window controller: one sampled switch tick in, one motor command out.
// The block takes one tick transfer per clock cycle unless stalled. The tick is
// captured in an input register, the controller state is updated by
// combinational logic as the tick moves on, and the motor command, the
// controlling source and the one-touch flag are held in a result register until
// taken. A stall on the result side holds both stages; the input side stalls
// only when the input register holds a tick while the result register is full
// and stalled.
// Timing counts are written through the configuration port (index 0 debounce,
// 1 hold, 2 obstacle confirm, 3 reverse); the port is always ready, and
// writes should only be made while no tick is in flight.
`include "power_window_controller_unit_assert.svh"

module power_window_controller_unit #(
  parameter int TIMER_BITS = pwc_pkg::TIMER_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Tick input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          passenger_up_i,
  input  logic                          passenger_down_i,
  input  logic                          driver_up_i,
  input  logic                          driver_down_i,
  input  logic                          obstacle_seen_i,
  input  logic                          lock_switch_i,
  input  logic                          top_limit_i,
  input  logic                          bottom_limit_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    motor_command_o,
  output logic [2:0]                    controlled_by_o,
  output logic                          one_touch_active_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pwc_pkg::CFG_W-1:0]     cfg_data_i
);

  logic [TIMER_BITS-1:0] debounce_eff, hold_eff, obstacle_eff, reverse_eff;

  // Pipeline handshake.
  logic                      s1_valid_q, s1_valid_d;
  logic [pwc_pkg::LV_W-1:0]  s1_lv_q;
  logic                      out_valid_q, out_valid_d;
  logic                      in_accept;
  logic                      advance;

  // Controller state.
  pwc_pkg::pwc_ctrl_t        ctrl_q, ctrl_d;
  logic [TIMER_BITS-1:0]     phase_timer_q, phase_timer_d;
  logic [TIMER_BITS-1:0]     obst_timer_q, obst_timer_d;

  // Result payload.
  logic [1:0]                motor_q;
  logic [2:0]                owner_q;
  logic                      one_touch_q;

  assign cfg_ready_o = 1'b1;

  pwc_cfg_regs #(
    .TIMER_BITS (TIMER_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .debounce_o  (debounce_eff),
    .hold_o      (hold_eff),
    .obstacle_o  (obstacle_eff),
    .reverse_o   (reverse_eff)
  );

  // The captured tick moves on unless a finished result is waiting and stalled.
  assign advance     = s1_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o  = s1_valid_q & out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign s1_valid_d  = in_accept | (s1_valid_q & ~advance);
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  pwc_step #(
    .TIMER_BITS (TIMER_BITS)
  ) u_step (
    .lv_i          (s1_lv_q),
    .ctrl_i        (ctrl_q),
    .phase_timer_i (phase_timer_q),
    .obst_timer_i  (obst_timer_q),
    .debounce_i    (debounce_eff),
    .hold_i        (hold_eff),
    .obstacle_i    (obstacle_eff),
    .reverse_i     (reverse_eff),
    .ctrl_o        (ctrl_d),
    .phase_timer_o (phase_timer_d),
    .obst_timer_o  (obst_timer_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
      ctrl_q.motor     <= pwc_pkg::M_STOP;
      ctrl_q.owner     <= pwc_pkg::O_NONE;
      ctrl_q.phase     <= pwc_pkg::P_IDLE;
      ctrl_q.button    <= pwc_pkg::B_NONE;
      ctrl_q.prev      <= '0;
      phase_timer_q    <= '0;
      obst_timer_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      // State only changes when a tick completes its update.
      if (advance) begin
        ctrl_q        <= ctrl_d;
        phase_timer_q <= phase_timer_d;
        obst_timer_q  <= obst_timer_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_lv_q <= {bottom_limit_i, top_limit_i, lock_switch_i, obstacle_seen_i,
                  driver_down_i, driver_up_i, passenger_down_i, passenger_up_i};
    end
    if (advance) begin
      motor_q     <= ctrl_d.motor;
      owner_q     <= ctrl_d.owner;
      one_touch_q <= (ctrl_d.phase == pwc_pkg::P_ONETOUCH);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign motor_command_o    = motor_q;
  assign controlled_by_o    = owner_q;
  assign one_touch_active_o = one_touch_q;

  // A completed update always lands in the result register.
  `PWC_ASSERT(a_advance_fills_out, advance |=> out_valid_q)
  // The input side is held off only while a tick sits in the input register.
  `PWC_ASSERT(a_stall_needs_s1, in_stall_o |-> s1_valid_q)
  // One-touch travel always has the motor running.
  `PWC_NEVER(a_onetouch_moving,
             ctrl_q.phase == pwc_pkg::P_ONETOUCH && ctrl_q.motor == pwc_pkg::M_STOP)
  // A reversal is owned by the obstacle logic and drives the window down.
  `PWC_ASSERT(a_reverse_down,
              ctrl_q.phase == pwc_pkg::P_REVERSE |->
              ctrl_q.motor == pwc_pkg::M_DOWN && ctrl_q.owner == pwc_pkg::O_OBST)

endmodule

// File: hw/rtl/pwc_cfg_regs.sv
// Timing configuration registers of the power window controller.
// Depends on pwc_pkg; delivers the effective (zero-free, clamped) tick counts.
module pwc_cfg_regs #(
  parameter int TIMER_BITS = pwc_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  input  logic [pwc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pwc_pkg::CFG_W-1:0]      cfg_data_i,
  output logic [TIMER_BITS-1:0]          debounce_o,
  output logic [TIMER_BITS-1:0]          hold_o,
  output logic [TIMER_BITS-1:0]          obstacle_o,
  output logic [TIMER_BITS-1:0]          reverse_o
);

  localparam int CW = pwc_pkg::CFG_W;
  localparam int WW = (TIMER_BITS > CW) ? TIMER_BITS : CW;

  logic [CW-1:0] debounce_q, hold_q, obstacle_q, reverse_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= pwc_pkg::DEBOUNCE_RST;
      hold_q     <= pwc_pkg::HOLD_RST;
      obstacle_q <= pwc_pkg::OBSTACLE_RST;
      reverse_q  <= pwc_pkg::REVERSE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pwc_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        pwc_pkg::CFG_HOLD:     hold_q     <= cfg_data_i;
        pwc_pkg::CFG_OBSTACLE: obstacle_q <= cfg_data_i;
        pwc_pkg::CFG_REVERSE:  reverse_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero count behaves as one; a count beyond the timer range is clamped.
  function automatic logic [TIMER_BITS-1:0] eff(input logic [CW-1:0] r);
    logic [CW-1:0] r1;
    logic [WW-1:0] rw;
    logic [WW-1:0] tmax;
    r1   = (r == '0) ? CW'(1) : r;
    rw   = WW'(r1);
    tmax = WW'({TIMER_BITS{1'b1}});
    return TIMER_BITS'((rw > tmax) ? tmax : rw);
  endfunction

  assign debounce_o = eff(debounce_q);
  assign hold_o     = eff(hold_q);
  assign obstacle_o = eff(obstacle_q);
  assign reverse_o  = eff(reverse_q);

endmodule

// File: hw/rtl/pwc_step.sv
// Next-state logic for one tick of the power window controller.
// Depends on pwc_pkg; purely combinational.
module pwc_step #(
  parameter int TIMER_BITS = pwc_pkg::TIMER_BITS_DEF
) (
  input  logic [pwc_pkg::LV_W-1:0] lv_i,
  input  pwc_pkg::pwc_ctrl_t       ctrl_i,
  input  logic [TIMER_BITS-1:0]    phase_timer_i,
  input  logic [TIMER_BITS-1:0]    obst_timer_i,
  input  logic [TIMER_BITS-1:0]    debounce_i,
  input  logic [TIMER_BITS-1:0]    hold_i,
  input  logic [TIMER_BITS-1:0]    obstacle_i,
  input  logic [TIMER_BITS-1:0]    reverse_i,
  output pwc_pkg::pwc_ctrl_t       ctrl_o,
  output logic [TIMER_BITS-1:0]    phase_timer_o,
  output logic [TIMER_BITS-1:0]    obst_timer_o
);

  always_comb begin
    logic [1:0]              m;
    logic [2:0]              o;
    logic [2:0]              ph;
    logic [2:0]              ab;
    logic [TIMER_BITS-1:0]   pt;
    logic [TIMER_BITS-1:0]   ot;
    logic [TIMER_BITS:0]     pt_inc;
    logic [pwc_pkg::LV_W-1:0] rise;
    logic                    lock;
    logic                    started;
    logic                    held;
    logic                    pass_btn;

    m       = ctrl_i.motor;
    o       = ctrl_i.owner;
    ph      = ctrl_i.phase;
    ab      = ctrl_i.button;
    pt      = phase_timer_i;
    ot      = obst_timer_i;
    rise    = lv_i & ~ctrl_i.prev;
    lock    = lv_i[pwc_pkg::LV_LOCK];
    started = 1'b0;

    // Lock drops any passenger activity.
    pass_btn = (ab == pwc_pkg::B_PU) || (ab == pwc_pkg::B_PD);
    if (lock && pass_btn) begin
      if (ph != pwc_pkg::P_DEBOUNCE) m = pwc_pkg::M_STOP;
      ph = pwc_pkg::P_IDLE;
      pt = '0;
      ab = pwc_pkg::B_NONE;
    end

    // New presses; driver first, down before up.
    pass_btn = (ab == pwc_pkg::B_PU) || (ab == pwc_pkg::B_PD);
    if (ph != pwc_pkg::P_REVERSE) begin
      if (rise[pwc_pkg::LV_DD]) begin
        ab = pwc_pkg::B_DD; started = 1'b1;
      end else if (rise[pwc_pkg::LV_DU]) begin
        ab = pwc_pkg::B_DU; started = 1'b1;
      end else if (!lock && (ph == pwc_pkg::P_IDLE || pass_btn)) begin
        if (rise[pwc_pkg::LV_PD]) begin
          ab = pwc_pkg::B_PD; started = 1'b1;
        end else if (rise[pwc_pkg::LV_PU]) begin
          ab = pwc_pkg::B_PU; started = 1'b1;
        end
      end
    end
    if (started) begin
      ph = pwc_pkg::P_DEBOUNCE;
      pt = '0;
    end

    case (ab)
      pwc_pkg::B_DU: held = lv_i[pwc_pkg::LV_DU];
      pwc_pkg::B_DD: held = lv_i[pwc_pkg::LV_DD];
      pwc_pkg::B_PU: held = lv_i[pwc_pkg::LV_PU];
      pwc_pkg::B_PD: held = lv_i[pwc_pkg::LV_PD];
      default:       held = 1'b0;
    endcase

    pt_inc = {1'b0, pt} + (TIMER_BITS+1)'(1);

    if (!started) begin
      unique case (ph)
        pwc_pkg::P_DEBOUNCE: begin
          if (!held) begin
            m  = pwc_pkg::M_STOP;
            ph = pwc_pkg::P_IDLE;
            pt = '0;
            ab = pwc_pkg::B_NONE;
          end else begin
            pt = pt_inc[TIMER_BITS-1:0];
            if (pt_inc >= {1'b0, debounce_i}) begin
              m  = (ab == pwc_pkg::B_DU || ab == pwc_pkg::B_PU) ?
                   pwc_pkg::M_UP : pwc_pkg::M_DOWN;
              o  = (ab == pwc_pkg::B_DU || ab == pwc_pkg::B_DD) ?
                   pwc_pkg::O_DRIVER : pwc_pkg::O_PASS;
              ph = pwc_pkg::P_HOLD;
              pt = '0;
            end
          end
        end
        pwc_pkg::P_HOLD: begin
          pt = pt_inc[TIMER_BITS-1:0];
          if (pt_inc >= {1'b0, hold_i}) begin
            ph = held ? pwc_pkg::P_MANUAL : pwc_pkg::P_ONETOUCH;
            pt = '0;
          end
        end
        pwc_pkg::P_MANUAL: begin
          if (!held) begin
            m  = pwc_pkg::M_STOP;
            ph = pwc_pkg::P_IDLE;
            pt = '0;
            ab = pwc_pkg::B_NONE;
          end
        end
        pwc_pkg::P_REVERSE: begin
          pt = pt_inc[TIMER_BITS-1:0];
          if (pt_inc >= {1'b0, reverse_i}) begin
            m  = pwc_pkg::M_STOP;
            ph = pwc_pkg::P_IDLE;
            pt = '0;
            ab = pwc_pkg::B_NONE;
          end
        end
        default: ;
      endcase
    end

    // The obstacle sensor reacts once per activation and rearms on clear.
    if (lv_i[pwc_pkg::LV_OBS]) begin
      if (ot < obstacle_i) begin
        ot = ot + TIMER_BITS'(1);
        if (ot >= obstacle_i && m == pwc_pkg::M_UP) begin
          m  = pwc_pkg::M_DOWN;
          o  = pwc_pkg::O_OBST;
          ph = pwc_pkg::P_REVERSE;
          pt = '0;
          ab = pwc_pkg::B_NONE;
        end
      end
    end else begin
      ot = '0;
    end

    // End switches stop travel in their direction.
    if ((m == pwc_pkg::M_UP && lv_i[pwc_pkg::LV_TOP]) ||
        (m == pwc_pkg::M_DOWN && lv_i[pwc_pkg::LV_BOT])) begin
      m = pwc_pkg::M_STOP;
      o = pwc_pkg::O_LIMIT;
      if (ph != pwc_pkg::P_DEBOUNCE) begin
        ph = pwc_pkg::P_IDLE;
        pt = '0;
        ab = pwc_pkg::B_NONE;
      end
    end

    ctrl_o.motor  = m;
    ctrl_o.owner  = o;
    ctrl_o.phase  = ph;
    ctrl_o.button = ab;
    ctrl_o.prev   = lv_i;
    phase_timer_o = pt;
    obst_timer_o  = ot;
  end

endmodule
